[hw/rtl/ddo_pkg.sv]
package ddo_pkg;

   localparam int COUNT_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 28;

   localparam logic [31:0] MPC_RESET = 32'd493674;
   localparam logic [31:0] IWB_RESET = 32'd45590261;

   localparam logic signed [33:0] TWO_PI  = 34'sd1686629713;
   localparam logic signed [33:0] PI      = 34'sd843314857;
   localparam logic signed [33:0] HALF_PI = 34'sd421657428;
   localparam logic signed [33:0] GAIN    = 34'sd652032874;

   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

   localparam logic [0:0] FUNC_TICK  = 1'b0;
   localparam logic [0:0] FUNC_RESET = 1'b1;

   localparam logic [0:0] REG_MPC = 1'b0;
   localparam logic [0:0] REG_IWB = 1'b1;

   // multiplier operand select
   localparam logic [2:0] MUL_TRAVEL = 3'd0;
   localparam logic [2:0] MUL_DQ     = 3'd1;
   localparam logic [2:0] MUL_TURN   = 3'd2;
   localparam logic [2:0] MUL_X      = 3'd3;
   localparam logic [2:0] MUL_Y      = 3'd4;

   typedef struct packed {
      logic       load;
      logic       clear_pose;
      logic       mul_go;
      logic       mul_save;
      logic [2:0] mul_sel;
      logic       theta_upd;
      logic       cordic_start;
      logic       cordic_step;
      logic       acc_upd;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic cordic_last;
   } status_type;

   function automatic logic [31:0] atan_q28(input logic [4:0] i);
      logic [31:0] t;
      case (i)
         5'd0:  t = 32'd210828714;
         5'd1:  t = 32'd124459457;
         5'd2:  t = 32'd65760959;
         5'd3:  t = 32'd33381290;
         5'd4:  t = 32'd16755422;
         5'd5:  t = 32'd8385879;
         5'd6:  t = 32'd4193963;
         5'd7:  t = 32'd2097109;
         5'd8:  t = 32'd1048571;
         5'd9:  t = 32'd524287;
         5'd29, 5'd30, 5'd31: t = 32'd0;
         default: t = 32'd1 << (5'd28 - i);
      endcase
      return t;
   endfunction

endpackage

[hw/rtl/ddo_if.sv]
interface ddo_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic signed [15:0] left_count;
   logic signed [15:0] right_count;
   modport source (output valid, func, left_count, right_count, input ready);
   modport sink   (input valid, func, left_count, right_count, output ready);
endinterface

interface ddo_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [47:0] pos_x;
   logic signed [47:0] pos_y;
   logic signed [31:0] heading;
   logic signed [47:0] travel;
   logic signed [31:0] turn;
   logic signed [47:0] distance_total;
   modport source (output valid, pos_x, pos_y, heading, travel, turn, distance_total,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, travel, turn, distance_total,
                   output ready);
endinterface

[hw/rtl/diff_drive_odometry.sv]
// Differential-drive odometry.
// req channel: func (tick or pose reset), left_count, right_count. One item is
// taken at a time; ready is high only while the block is idle.
// rsp channel: pose, heading, travel, turn and total distance, one item per
// request item, held until taken.
// A tick runs the travel, difference and turn products through the shared
// 4-bit-per-cycle multiplier, updates the heading, runs the CORDIC loop,
// forms the x and y products and accumulates; the next item can be taken in
// the cycle after the result is taken. A pose reset result is valid in the
// cycle after the item is taken. The multiplier and the CORDIC loop set how
// long a tick takes.
// csr: APB-style write/read of meters_per_count (0x0) and
// inverse_wheel_base (0x4); write only while idle.
// Reset: pose, heading and distance clear, registers go to defaults.
// A stalled receiver holds the result and keeps req_ready low.
module diff_drive_odometry #(
   parameter int COUNT_WIDTH  = ddo_pkg::COUNT_WIDTH_DEF,
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ddo_req_if.sink     req,
   ddo_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ddo_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [31:0] mpc_ff, iwb_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_IWB) ? iwb_ff : mpc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mpc_ff <= MPC_RESET;
         iwb_ff <= IWB_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == REG_MPC) mpc_ff <= csr_pwdata;
         else iwb_ff <= csr_pwdata;
      end
   end

   ddo_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_func(req.func),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .status(status)
   );

   ddo_datapath #(.COUNT_WIDTH(COUNT_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .left_count(req.left_count), .right_count(req.right_count),
      .mpc(mpc_ff), .iwb(iwb_ff),
      .pos_x(rsp.pos_x), .pos_y(rsp.pos_y), .heading(rsp.heading),
      .travel(rsp.travel), .turn(rsp.turn), .distance_total(rsp.distance_total)
   );

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.pos_x))
      else $error("result dropped");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready) else $error("double accept");

endmodule

[hw/rtl/ddo_ctrl.sv]
module ddo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ddo_pkg::cmd_type    cmd,
   input  ddo_pkg::status_type status
);
   import ddo_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TRAV   = 4'd1;
   localparam logic [3:0] S_DQ     = 4'd2;
   localparam logic [3:0] S_TURN   = 4'd3;
   localparam logic [3:0] S_THETA  = 4'd4;
   localparam logic [3:0] S_CORDIC = 4'd5;
   localparam logic [3:0] S_MX     = 4'd6;
   localparam logic [3:0] S_MY     = 4'd7;
   localparam logic [3:0] S_ACC    = 4'd8;
   localparam logic [3:0] S_OUT    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       go_ff, go_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      go_in    = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_RESET) begin
                  cmd.clear_pose = 1'b1;
                  state_in = S_OUT;
               end else begin
                  go_in = 1'b1;
                  state_in = S_TRAV;
               end
            end
         end
         S_TRAV, S_DQ, S_TURN, S_MX, S_MY: begin
            cmd.mul_go = go_ff;
            unique case (state_ff)
               S_TRAV:  cmd.mul_sel = MUL_TRAVEL;
               S_DQ:    cmd.mul_sel = MUL_DQ;
               S_TURN:  cmd.mul_sel = MUL_TURN;
               S_MX:    cmd.mul_sel = MUL_X;
               default: cmd.mul_sel = MUL_Y;
            endcase
            if (!go_ff && status.mul_done) begin
               cmd.mul_save = 1'b1;
               unique case (state_ff)
                  S_TRAV: begin state_in = S_DQ; go_in = 1'b1; end
                  S_DQ:   begin state_in = S_TURN; go_in = 1'b1; end
                  S_TURN: state_in = S_THETA;
                  S_MX:   begin state_in = S_MY; go_in = 1'b1; end
                  default: state_in = S_ACC;
               endcase
            end
         end
         S_THETA: begin
            cmd.theta_upd = 1'b1;
            state_in = S_CORDIC;
            go_in = 1'b1;
         end
         S_CORDIC: begin
            if (go_ff) cmd.cordic_start = 1'b1;
            else begin
               cmd.cordic_step = 1'b1;
               if (status.cordic_last) begin
                  state_in = S_MX;
                  go_in = 1'b1;
               end
            end
         end
         S_ACC: begin
            cmd.acc_upd = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

endmodule

[hw/rtl/ddo_datapath.sv]
module ddo_datapath #(
   parameter int COUNT_WIDTH  = ddo_pkg::COUNT_WIDTH_DEF,
   parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ddo_pkg::cmd_type     cmd,
   output ddo_pkg::status_type  status,
   input  logic signed [15:0]   left_count,
   input  logic signed [15:0]   right_count,
   input  logic [31:0]          mpc,
   input  logic [31:0]          iwb,
   output logic signed [47:0]   pos_x,
   output logic signed [47:0]   pos_y,
   output logic signed [31:0]   heading,
   output logic signed [47:0]   travel,
   output logic signed [31:0]   turn,
   output logic signed [47:0]   distance_total
);
   import ddo_pkg::*;

   localparam int SW = COUNT_WIDTH + 2;
   localparam int IW = $clog2(CORDIC_STEPS + 1);

   logic signed [SW-1:0] sum_ff, dif_ff;
   logic signed [47:0] x_ff, y_ff, tot_ff, trav_ff;
   logic signed [31:0] th_ff, turn_ff;
   logic signed [47:0] dq_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic [IW-1:0]      it_ff;
   logic signed [63:0] dx_ff, dy_ff;

   logic signed [COUNT_WIDTH-1:0] lc, rc;
   logic signed [SW-1:0] lneg, rext;
   assign lc = COUNT_WIDTH'(left_count);
   assign rc = COUNT_WIDTH'(right_count);
   assign lneg = -SW'(lc);
   assign rext = SW'(rc);

   // shared serial magnitude multiplier: 64-bit a times 32-bit b, 4 bits a cycle
   logic [63:0] ma_ff;
   logic [31:0] mb_ff;
   logic [95:0] acc_ff;
   logic        mneg_ff;
   logic [3:0]  mcnt_ff;
   logic        mbusy_ff;
   logic [5:0]  mshift;
   logic signed [63:0] opa;
   logic signed [32:0] opb;

   always_comb begin
      opa = '0; opb = '0; mshift = 6'd1;
      case (cmd.mul_sel)
         MUL_TRAVEL: begin opa = 64'(sum_ff); opb = $signed({1'b0, mpc}); mshift = 6'd1; end
         MUL_DQ:     begin opa = 64'(dif_ff); opb = $signed({1'b0, mpc}); mshift = 6'd8; end
         MUL_TURN:   begin opa = 64'(dq_ff);  opb = $signed({1'b0, iwb}); mshift = 6'd20; end
         MUL_X:      begin opa = 64'(trav_ff); opb = cx_ff[32:0]; mshift = 6'd30; end
         default:    begin opa = 64'(trav_ff); opb = cy_ff[32:0]; mshift = 6'd30; end
      endcase
   end

   logic [95:0] prod_sh;
   logic [63:0] mres_mag;
   logic signed [63:0] mres;
   logic [35:0] part;
   assign part = {4'b0, mb_ff} * {32'b0, ma_ff[63:60]};
   assign prod_sh = acc_ff >> mshift;
   assign mres_mag = (prod_sh[95:62] != 0 && prod_sh > (96'd1 << 62)) ? (64'd1 << 62)
                     : prod_sh[63:0];
   assign mres = mneg_ff ? -$signed(mres_mag) : $signed(mres_mag);
   assign status.mul_done = !mbusy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
      end else if (cmd.mul_go) begin
         mbusy_ff <= 1'b1;
      end else if (mbusy_ff && mcnt_ff == 4'd15) begin
         mbusy_ff <= 1'b0;
      end
      if (cmd.mul_go) begin
         ma_ff   <= opa[63] ? 64'(-opa) : opa;
         mb_ff   <= opb[32] ? 32'(-opb) : opb[31:0];
         mneg_ff <= opa[63] ^ opb[32];
         acc_ff  <= '0;
         mcnt_ff <= '0;
      end else if (mbusy_ff) begin
         acc_ff  <= (acc_ff << 4) + 96'(part);
         ma_ff   <= ma_ff << 4;
         mcnt_ff <= mcnt_ff + 4'd1;
      end
   end

   function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
      if (v > 65'(MAX48)) return MAX48;
      if (v < 65'(MIN48)) return MIN48;
      return v[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      if (v > 65'(MAX32)) return MAX32;
      if (v < 65'(MIN32)) return MIN32;
      return v[31:0];
   endfunction

   logic signed [32:0] th_sum;
   logic signed [33:0] th_a, th_b;
   logic signed [31:0] th_sat;
   logic signed [33:0] z0, z1;
   logic               fl;
   assign th_sum = 33'(th_ff) + 33'(turn_ff);
   assign th_sat = sat32(65'(th_sum));
   always_comb begin
      th_a = 34'(th_sat);
      if (th_a >= TWO_PI) th_a = th_a - TWO_PI;
      th_b = th_a;
      if (th_b <= -TWO_PI) th_b = th_b + TWO_PI;
      z0 = 34'(th_ff);
      if (z0 > PI) z0 = z0 - TWO_PI;
      if (z0 < -PI) z0 = z0 + TWO_PI;
      fl = 1'b0;
      z1 = z0;
      if (z0 > HALF_PI) begin z1 = z0 - PI; fl = 1'b1; end
      else if (z0 < -HALF_PI) begin z1 = z0 + PI; fl = 1'b1; end
   end

   logic [31:0] at;
   logic signed [33:0] xs, ys;
   assign at = atan_q28(it_ff[4:0]);
   assign xs = cx_ff >>> it_ff;
   assign ys = cy_ff >>> it_ff;
   assign status.cordic_last = (it_ff == IW'(CORDIC_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; y_ff <= '0; th_ff <= '0; tot_ff <= '0;
      end else begin
         if (cmd.clear_pose) begin
            x_ff <= '0; y_ff <= '0; th_ff <= '0;
         end
         if (cmd.theta_upd) th_ff <= th_b[31:0];
         if (cmd.acc_upd) begin
            x_ff   <= sat48(65'(x_ff) + 65'(dx_ff));
            y_ff   <= sat48(65'(y_ff) + 65'(dy_ff));
            tot_ff <= sat48(65'(tot_ff) + 65'(trav_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_ff  <= lneg + rext;
         dif_ff  <= rext - lneg;
         trav_ff <= '0;
         turn_ff <= '0;
      end
      if (cmd.mul_save) begin
         case (cmd.mul_sel)
            MUL_TRAVEL: trav_ff <= sat48(65'(mres));
            MUL_DQ:     dq_ff   <= mres[47:0];
            MUL_TURN:   turn_ff <= sat32(65'(mres));
            MUL_X:      dx_ff   <= mres;
            default:    dy_ff   <= mres;
         endcase
      end
      if (cmd.cordic_start) begin
         cx_ff <= GAIN; cy_ff <= '0; cz_ff <= z1; flip_ff <= fl; it_ff <= '0;
      end else if (cmd.cordic_step) begin
         if (status.cordic_last) begin
            if (flip_ff) begin
               cx_ff <= -((cz_ff >= 0) ? cx_ff - ys : cx_ff + ys);
               cy_ff <= -((cz_ff >= 0) ? cy_ff + xs : cy_ff - xs);
            end else begin
               cx_ff <= (cz_ff >= 0) ? cx_ff - ys : cx_ff + ys;
               cy_ff <= (cz_ff >= 0) ? cy_ff + xs : cy_ff - xs;
            end
         end else begin
            cx_ff <= (cz_ff >= 0) ? cx_ff - ys : cx_ff + ys;
            cy_ff <= (cz_ff >= 0) ? cy_ff + xs : cy_ff - xs;
         end
         cz_ff <= (cz_ff >= 0) ? cz_ff - 34'(at) : cz_ff + 34'(at);
         it_ff <= it_ff + IW'(1);
      end
   end

   assign pos_x = x_ff;
   assign pos_y = y_ff;
   assign heading = th_ff;
   assign travel = trav_ff;
   assign turn = turn_ff;
   assign distance_total = tot_ff;

endmodule
